/* hdl/lpsa_pkg.sv */
// lpsa_pkg: shared types, constants and the arctangent table for the steering angle block
`default_nettype none

package lpsa_pkg;

  localparam int MAX_ROWS     = 1024;
  localparam int ROW_MARGIN   = 11;
  localparam int CORDIC_ITERS = 16;

  localparam int CoordW  = 10;
  localparam int CountW  = 11;
  localparam int SpeedW  = 16;
  localparam int AngleW  = 16;
  localparam int TxW     = 12;
  localparam int TyW     = 11;
  localparam int DxW     = 13;
  localparam int DyW     = 12;
  localparam int MagW    = 11;
  localparam int CW      = 26;
  localparam int PreShift = 12;
  localparam int RowIdxW = $clog2(2 * MAX_ROWS);
  localparam int CmpW    = ((RowIdxW > CountW) ? RowIdxW : CountW) + 2;
  localparam int IterW   = $clog2(CORDIC_ITERS);
  localparam int AtanIdxW = 5;
  localparam int AtanW   = 22;
  localparam int RowIdxMax = 2 * MAX_ROWS - 1;
  localparam int AngleLimit = 23040;
  localparam int RoundHalf = 128;
  localparam int RoundShift = 8;
  localparam int RoundW  = CW - RoundShift;

  typedef enum logic [7:0] {
    REG_CAR_X      = 8'd0,
    REG_CAR_Y      = 8'd1,
    REG_LANE_WIDTH = 8'd2,
    REG_ROW_COUNT  = 8'd3
  } reg_index_t;

  typedef struct packed {
    logic [CoordW-1:0] left_x;
    logic [CoordW-1:0] left_y;
    logic [CoordW-1:0] right_x;
    logic [CoordW-1:0] right_y;
    logic [SpeedW-1:0] speed_in;
    logic              last_row;
  } row_item_t;

  typedef struct packed {
    logic signed [AngleW-1:0] steer_angle;
    logic        [SpeedW-1:0] speed_out;
  } result_item_t;

  typedef struct packed {
    logic                  found;
    logic signed [TxW-1:0] target_x;
    logic        [TyW-1:0] target_y;
  } target_t;

  typedef struct packed {
    logic                  start;
    logic signed [DxW-1:0] dx;
    logic signed [DyW-1:0] dy;
    logic     [SpeedW-1:0] speed;
  } cordic_req_t;

  localparam logic [AtanW-1:0] AtanTab [24] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0
  };

  function automatic logic [AtanW-1:0] atan_entry(input logic [IterW-1:0] i);
    return AtanTab[AtanIdxW'(i)];
  endfunction

endpackage

`default_nettype wire

/* hdl/lpsa_row_sel.sv */
// lpsa_row_sel: row counter and target point latch for one frame
`default_nettype none

module lpsa_row_sel (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire lpsa_pkg::row_item_t           row,
  input  wire logic [lpsa_pkg::CoordW-1:0]   lane_width,
  input  wire logic [lpsa_pkg::CountW-1:0]   row_count,
  output lpsa_pkg::target_t                  tgt
);

  logic [lpsa_pkg::RowIdxW-1:0] row_index;
  logic                         found_flag;
  logic signed [lpsa_pkg::TxW-1:0] target_x;
  logic        [lpsa_pkg::TyW-1:0] target_y;

  logic has_l, has_r, qualify;
  logic [lpsa_pkg::CoordW-2:0] half;
  logic [lpsa_pkg::CoordW:0] sum_x, sum_y;
  logic [lpsa_pkg::CoordW:0] mid_x, mid_y;
  logic signed [lpsa_pkg::TxW-1:0] new_x;
  logic        [lpsa_pkg::TyW-1:0] new_y;
  logic [lpsa_pkg::CmpW-1:0] reach;

  assign has_l = (row.left_x != '0) || (row.left_y != '0);
  assign has_r = (row.right_x != '0) || (row.right_y != '0);
  assign half  = lane_width[lpsa_pkg::CoordW-1:1];
  assign reach = lpsa_pkg::CmpW'(row_index) + lpsa_pkg::CmpW'(lpsa_pkg::ROW_MARGIN);
  assign qualify = (reach <= lpsa_pkg::CmpW'(row_count)) && (has_l || has_r);

  // midpoint rounded half to even
  assign sum_x = {1'b0, row.left_x} + {1'b0, row.right_x};
  assign sum_y = {1'b0, row.left_y} + {1'b0, row.right_y};
  assign mid_x = {1'b0, sum_x[lpsa_pkg::CoordW:1]} + {{lpsa_pkg::CoordW{1'b0}},
                 (sum_x[0] & sum_x[1])};
  assign mid_y = {1'b0, sum_y[lpsa_pkg::CoordW:1]} + {{lpsa_pkg::CoordW{1'b0}},
                 (sum_y[0] & sum_y[1])};

  always_comb begin
    priority if (has_l && has_r) begin
      new_x = $signed(lpsa_pkg::TxW'(mid_x));
      new_y = lpsa_pkg::TyW'(mid_y);
    end else if (has_l) begin
      new_x = $signed(lpsa_pkg::TxW'(row.left_x)) + $signed(lpsa_pkg::TxW'(half));
      new_y = lpsa_pkg::TyW'(row.left_y);
    end else begin
      new_x = $signed(lpsa_pkg::TxW'(row.right_x)) - $signed(lpsa_pkg::TxW'(half));
      new_y = lpsa_pkg::TyW'(row.right_y);
    end
  end

  always_comb begin
    tgt.found    = found_flag || qualify;
    tgt.target_x = qualify ? new_x : target_x;
    tgt.target_y = qualify ? new_y : target_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index  <= '0;
      found_flag <= 1'b0;
      target_x   <= '0;
      target_y   <= '0;
    end else if (accept) begin
      target_x <= tgt.target_x;
      target_y <= tgt.target_y;
      if (row.last_row) begin
        row_index  <= '0;
        found_flag <= 1'b0;
      end else begin
        found_flag <= tgt.found;
        if (row_index != lpsa_pkg::RowIdxW'(lpsa_pkg::RowIdxMax)) begin
          row_index <= row_index + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/lpsa_cordic.sv */
// lpsa_cordic: sequencer around one shared vectoring step, with the result register
`default_nettype none

module lpsa_cordic (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lpsa_pkg::cordic_req_t req,
  output logic                       busy,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output lpsa_pkg::result_item_t     out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_ROUND,
    S_EMIT
  } state_t;

  state_t state;
  logic [lpsa_pkg::IterW-1:0] iter;
  logic signed [lpsa_pkg::CW-1:0] x, y, z;
  logic signed [lpsa_pkg::AngleW-1:0] angle;
  logic [lpsa_pkg::SpeedW-1:0] speed;
  logic negate;

  logic [lpsa_pkg::DxW-1:0] mag_dx;
  logic [lpsa_pkg::DyW-1:0] mag_dy;
  logic signed [lpsa_pkg::CW-1:0] x_init, y_init;
  logic signed [lpsa_pkg::CW-1:0] xs, ys, at;
  logic signed [lpsa_pkg::CW-1:0] x_next, y_next, z_next;
  logic signed [lpsa_pkg::CW-1:0] z_round;
  logic signed [lpsa_pkg::RoundW-1:0] m;
  logic [lpsa_pkg::AngleW-1:0] m_clamp;
  logic out_free;

  assign busy     = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign mag_dx = req.dx[lpsa_pkg::DxW-1] ? lpsa_pkg::DxW'(-req.dx) : lpsa_pkg::DxW'(req.dx);
  assign mag_dy = req.dy[lpsa_pkg::DyW-1] ? lpsa_pkg::DyW'(-req.dy) : lpsa_pkg::DyW'(req.dy);
  assign x_init = $signed(lpsa_pkg::CW'(mag_dy[lpsa_pkg::MagW-1:0]) << lpsa_pkg::PreShift);
  assign y_init = $signed(lpsa_pkg::CW'(mag_dx[lpsa_pkg::MagW-1:0]) << lpsa_pkg::PreShift);

  // shared vectoring step
  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign at = $signed(lpsa_pkg::CW'(lpsa_pkg::atan_entry(iter)));

  always_comb begin
    if (!y[lpsa_pkg::CW-1]) begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + at;
    end else begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - at;
    end
  end

  // round to 1/256 degree and clamp
  assign z_round = z + lpsa_pkg::CW'(lpsa_pkg::RoundHalf);
  assign m = lpsa_pkg::RoundW'(z_round >>> lpsa_pkg::RoundShift);

  always_comb begin
    priority if (m < 0) begin
      m_clamp = '0;
    end else if (m > lpsa_pkg::RoundW'(lpsa_pkg::AngleLimit)) begin
      m_clamp = lpsa_pkg::AngleW'(lpsa_pkg::AngleLimit);
    end else begin
      m_clamp = lpsa_pkg::AngleW'(m);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      iter      <= '0;
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            speed  <= req.speed;
            negate <= req.dx[lpsa_pkg::DxW-1] ^ req.dy[lpsa_pkg::DyW-1];
            x      <= x_init;
            y      <= y_init;
            z      <= '0;
            iter   <= '0;
            priority if (req.dx == '0) begin
              angle <= '0;
              state <= S_EMIT;
            end else if (req.dy == '0) begin
              angle <= req.dx[lpsa_pkg::DxW-1] ? -lpsa_pkg::AngleW'(lpsa_pkg::AngleLimit)
                                               : lpsa_pkg::AngleW'(lpsa_pkg::AngleLimit);
              state <= S_EMIT;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          x    <= x_next;
          y    <= y_next;
          z    <= z_next;
          iter <= iter + 1'b1;
          if (iter == lpsa_pkg::IterW'(lpsa_pkg::CORDIC_ITERS - 1)) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          angle <= negate ? -$signed(m_clamp) : $signed(m_clamp);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_data.steer_angle <= angle;
            out_data.speed_out   <= speed;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/lane_point_steering_angle_core.sv */
// lane_point_steering_angle_core: top level of the lane point steering angle block
//
// Lane rows stream in one per cycle when not stalled, each taken in the cycle it is
// offered; the highest qualifying row's target point is latched. A last row with a target
// found stalls the input for 16 vectoring steps in one shared shift/add unit, one rounding
// step and one transfer into the output register, or for the transfer alone when the target
// lies straight ahead or level. A result waiting in the output register does not hold up
// ordinary rows; the next result-bearing last row is taken, but its result waits, input
// stalled, until the old one is taken. Registers car_x, car_y, lane_width and row_count sit
// at indexes 0 to 3 of the config port, which is always ready; other indexes are ignored.
`default_nettype none

module lane_point_steering_angle_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire lpsa_pkg::row_item_t           in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output lpsa_pkg::result_item_t             out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [7:0]                    cfg_index,
  input  wire logic [15:0]                   cfg_data
);

  logic [lpsa_pkg::CoordW-1:0] car_x, car_y, lane_width;
  logic [lpsa_pkg::CountW-1:0] row_count;
  logic accept, busy;
  lpsa_pkg::target_t tgt;
  lpsa_pkg::cordic_req_t req;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      car_x      <= '0;
      car_y      <= '0;
      lane_width <= '0;
      row_count  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lpsa_pkg::REG_CAR_X:      car_x      <= cfg_data[lpsa_pkg::CoordW-1:0];
        lpsa_pkg::REG_CAR_Y:      car_y      <= cfg_data[lpsa_pkg::CoordW-1:0];
        lpsa_pkg::REG_LANE_WIDTH: lane_width <= cfg_data[lpsa_pkg::CoordW-1:0];
        lpsa_pkg::REG_ROW_COUNT:  row_count  <= cfg_data[lpsa_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  lpsa_row_sel u_row_sel (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .row        (in_data),
    .lane_width (lane_width),
    .row_count  (row_count),
    .tgt        (tgt)
  );

  always_comb begin
    req.start = accept && in_data.last_row && tgt.found;
    req.dx    = lpsa_pkg::DxW'(tgt.target_x) - $signed(lpsa_pkg::DxW'(car_x));
    req.dy    = $signed(lpsa_pkg::DyW'(car_y)) - $signed(lpsa_pkg::DyW'(tgt.target_y));
    req.speed = in_data.speed_in;
  end

  lpsa_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* hdl/lpsa_checker.sv */
// lpsa_checker: port level assertions for the steering angle block, bound to the top level
`default_nettype none

module lpsa_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire lpsa_pkg::row_item_t    in_data,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire lpsa_pkg::result_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // an ordinary row never leaves the block busy
  a_row_no_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !in_data.last_row |=> !in_stall)
    else $error("stall after ordinary row");

  // busy only begins with a last row transfer
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && in_data.last_row))
    else $error("stall without last row");

  // a fresh result follows a busy period
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without computation");

endmodule

bind lane_point_steering_angle_core lpsa_checker u_lpsa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
